FILE: hdl/lbc_pkg.sv
// Package: shared constants and types for the LRU block cache.
`default_nettype none
package lbc_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int BLOCK_WORDS = 32;
	localparam int DISKS = 16;
	localparam int BLOCKS_PER_DISK = 256;
	localparam int ENTRY_W = $clog2(MAX_ENTRIES);
	localparam int WORD_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int STORE_DEPTH = MAX_ENTRIES * BLOCK_WORDS;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = ENTRY_W + 1;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// One tag table entry: key and access stamp
	typedef struct packed {
		logic [7:0]  disk;
		logic [9:0]  blk;
		logic [31:0] stamp;
	} entry_t;

	localparam logic [0:0] REG_CACHE_ON = 1'b0;
	localparam logic [0:0] REG_ACTIVE   = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/lbc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: hdl/lru_block_cache_top.sv
// Top level of the LRU block cache: config port, tag scan sequencer, block store.
//
//  channel | signals                                          | dir
//  in      | in_valid, in_stall, cmd, disk_number, block_number, data_word, last_word | in
//  out     | out_valid, out_stall, status, read_word, final_result, hit_total, query_total | out
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
// One shared comparator walks the tag/stamp RAM one entry a cycle, working on the entry
// addressed the cycle before, since the RAM read is registered. A lookup or the first word
// of an insert or update stays busy through scan, decide, then write or reply; an insert
// that must evict walks the stamps again. Later burst words stay busy through a write, plus
// the reply on the last word. A hit streams BLOCK_WORDS results, each read and then
// presented, each waiting on out_stall, and then retires. Reset clears valid bits,
// counters and clock.
`default_nettype none
module lru_block_cache_top
	import lbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  disk_number,
	input  wire logic [9:0]  block_number,
	input  wire logic [63:0] data_word,
	input  wire logic        last_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [63:0]      read_word,
	output logic             final_result,
	output logic [31:0]      hit_total,
	output logic [31:0]      query_total,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:2]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_EVICT, ST_DECIDE, ST_WRITE, ST_READ, ST_OUT
	} state_t;

	state_t state_q;
	logic cache_on_q;
	logic [CNT_W-1:0] active_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [31:0] clock_q, hits_q, queries_q;
	logic [WORD_W-1:0] pos_q;
	logic [ENTRY_W-1:0] slot_q, idx_q, best_q, free_q, match_q;
	logic [31:0] best_stamp_q;
	logic found_q, free_found_q, open_q, rej_q;
	cmd_t cmd_q;
	logic [7:0] disk_q;
	logic [9:0] blk_q;
	logic [63:0] word_q;
	logic last_q, good_q;
	logic [WORD_W-1:0] rd_q;
	logic rd_last_q;
	// entry whose RAM data is on ent_rdata this cycle
	logic [ENTRY_W-1:0] chk_idx_s1;
	logic chk_vld_s1, chk_last_s1;

	// Tag/stamp RAM, one port shared by scan reads and decide writes.
	logic ent_we;
	logic [ENTRY_W-1:0] ent_addr;
	entry_t ent_wdata, ent_rdata;
	always_comb begin
		ent_we = 1'b0;
		ent_addr = idx_q;
		ent_wdata.disk = disk_q;
		ent_wdata.blk = blk_q;
		ent_wdata.stamp = clock_q + 32'd1;
		if (state_q == ST_DECIDE && good_q) begin
			case (cmd_q)
				CMD_LOOKUP: begin
					ent_we = found_q;
					ent_addr = match_q;
				end
				CMD_INSERT: begin
					// no write yet when an eviction pass is still due
					ent_we = !found_q && free_found_q;
					ent_addr = free_q;
				end
				CMD_UPDATE: begin
					ent_we = found_q;
					ent_addr = match_q;
					ent_wdata.stamp = clock_q;
				end
				default: ent_we = 1'b0;
			endcase
		end
	end
	lbc_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_entries (
		.clk(clk), .we(ent_we), .addr(ent_addr), .wdata(ent_wdata), .rdata(ent_rdata)
	);

	// Shared scan unit: key match and stamp compare for entry chk_idx_s1.
	logic key_hit, take_best;
	assign key_hit = valid_q[chk_idx_s1] && ent_rdata.disk == disk_q
		&& ent_rdata.blk == blk_q;
	assign take_best = (chk_idx_s1 == '0) || (ent_rdata.stamp < best_stamp_q);
	logic scan_end;
	assign scan_end = ({1'b0, idx_q} == active_q - CNT_W'(1));

	// Block store.
	logic we;
	logic [ADDR_W-1:0] addr;
	logic [63:0] rdata;
	always_comb begin
		we = (state_q == ST_WRITE) && !rej_q;
		if (state_q == ST_WRITE)
			addr = ADDR_W'({slot_q, pos_q});
		else
			addr = ADDR_W'({match_q, rd_q});
	end
	lbc_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_store (
		.clk(clk), .we(we), .addr(addr), .wdata(word_q), .rdata(rdata)
	);

	assign pready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign prdata = paddr[2] ? 32'(active_q) : {31'd0, cache_on_q};
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	function automatic logic [CNT_W-1:0] clamp(input logic [6:0] v);
		if (v < 7'd2) return CNT_W'(2);
		if (32'(v) > MAX_ENTRIES) return CNT_W'(MAX_ENTRIES);
		return CNT_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cache_on_q <= 1'b0;
			active_q <= clamp(7'd64);
			valid_q <= '0;
			clock_q <= '0;
			hits_q <= '0;
			queries_q <= '0;
			open_q <= 1'b0;
			rej_q <= 1'b0;
			pos_q <= '0;
			slot_q <= '0;
			idx_q <= '0;
			best_q <= '0;
			free_q <= '0;
			match_q <= '0;
			best_stamp_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			cmd_q <= CMD_LOOKUP;
			disk_q <= '0;
			blk_q <= '0;
			word_q <= '0;
			last_q <= 1'b0;
			good_q <= 1'b0;
			rd_q <= '0;
			rd_last_q <= 1'b0;
			chk_idx_s1 <= '0;
			chk_vld_s1 <= 1'b0;
			chk_last_s1 <= 1'b0;
			out_valid <= 1'b0;
			status <= 1'b0;
			read_word <= '0;
			final_result <= 1'b0;
			hit_total <= '0;
			query_total <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_ACTIVE) begin
					active_q <= clamp(pwdata[6:0]);
				end
				if (paddr[2] == REG_ACTIVE || !pwdata[0]) begin
					valid_q <= '0;
					open_q <= 1'b0;
					rej_q <= 1'b0;
					pos_q <= '0;
					slot_q <= '0;
				end
				if (paddr[2] == REG_CACHE_ON) cache_on_q <= pwdata[0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd_t'(cmd);
						disk_q <= disk_number;
						blk_q <= block_number;
						word_q <= data_word;
						last_q <= last_word;
						good_q <= cache_on_q && 32'(disk_number) < DISKS
							&& 32'(block_number) < BLOCKS_PER_DISK;
						idx_q <= '0;
						best_q <= '0;
						chk_vld_s1 <= 1'b0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						if (cmd_t'(cmd) == CMD_NONE) state_q <= ST_IDLE;
						else if (cmd_t'(cmd) == CMD_LOOKUP || !open_q) state_q <= ST_SCAN;
						else state_q <= ST_WRITE;
					end
				end
				ST_SCAN: begin
					if (chk_vld_s1 && key_hit && !found_q) begin
						found_q <= 1'b1;
						match_q <= chk_idx_s1;
					end
					if (chk_vld_s1 && !valid_q[chk_idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= chk_idx_s1;
					end
					if (chk_vld_s1 && chk_last_s1) begin
						chk_vld_s1 <= 1'b0;
						idx_q <= '0;
						state_q <= ST_DECIDE;
					end else begin
						chk_idx_s1 <= idx_q;
						chk_vld_s1 <= 1'b1;
						chk_last_s1 <= scan_end;
						idx_q <= idx_q + ENTRY_W'(1);
					end
				end
				ST_EVICT: begin
					// lowest stamp wins, lowest index on ties
					if (chk_vld_s1 && take_best) begin
						best_q <= chk_idx_s1;
						best_stamp_q <= ent_rdata.stamp;
					end
					if (chk_vld_s1 && chk_last_s1) begin
						free_found_q <= 1'b1;
						free_q <= take_best ? chk_idx_s1 : best_q;
						chk_vld_s1 <= 1'b0;
						idx_q <= '0;
						state_q <= ST_DECIDE;
					end else begin
						chk_idx_s1 <= idx_q;
						chk_vld_s1 <= 1'b1;
						chk_last_s1 <= scan_end;
						idx_q <= idx_q + ENTRY_W'(1);
					end
				end
				ST_DECIDE: begin
					if (cmd_q == CMD_LOOKUP) begin
						queries_q <= queries_q + 32'd1;
						if (good_q && found_q) begin
							clock_q <= clock_q + 32'd1;
							hits_q <= hits_q + 32'd1;
							rd_q <= '0;
							state_q <= ST_READ;
						end else begin
							status <= 1'b1;
							read_word <= '0;
							final_result <= 1'b1;
							hit_total <= hits_q;
							query_total <= queries_q + 32'd1;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end else if (good_q && cmd_q == CMD_INSERT && !found_q
							&& !free_found_q) begin
						chk_vld_s1 <= 1'b0;
						idx_q <= '0;
						state_q <= ST_EVICT;
					end else begin
						open_q <= 1'b1;
						pos_q <= '0;
						state_q <= ST_WRITE;
						if (!good_q) begin
							rej_q <= 1'b1;
							slot_q <= '0;
						end else if (cmd_q == CMD_INSERT) begin
							if (found_q) begin
								rej_q <= 1'b1;
								slot_q <= '0;
							end else begin
								rej_q <= 1'b0;
								clock_q <= clock_q + 32'd1;
								valid_q[free_q] <= 1'b1;
								slot_q <= free_q;
							end
						end else begin
							rej_q <= !found_q;
							if (found_q) slot_q <= match_q;
							else slot_q <= '0;
						end
					end
				end
				ST_WRITE: begin
					// store write happens this cycle unless the burst is rejected
					if (last_q) begin
						status <= rej_q;
						read_word <= '0;
						final_result <= 1'b1;
						hit_total <= hits_q;
						query_total <= queries_q;
						out_valid <= 1'b1;
						open_q <= 1'b0;
						rej_q <= 1'b0;
						pos_q <= '0;
						slot_q <= '0;
						state_q <= ST_OUT;
					end else begin
						pos_q <= (32'(pos_q) == BLOCK_WORDS - 1) ? '0 : pos_q + WORD_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// address rd_q presented; data next cycle
					if (out_valid && !out_stall) out_valid <= 1'b0;
					rd_last_q <= (32'(rd_q) == BLOCK_WORDS - 1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						if (cmd_q == CMD_LOOKUP && good_q && found_q && !final_result
								&& !(out_valid && final_result)) begin
							status <= 1'b0;
							read_word <= rdata;
							final_result <= rd_last_q;
							hit_total <= hits_q;
							query_total <= queries_q;
							out_valid <= 1'b1;
							if (rd_last_q) state_q <= ST_OUT;
							else begin
								rd_q <= rd_q + WORD_W'(1);
								state_q <= ST_READ;
							end
						end else if (!out_valid || !out_stall) begin
							if (!(out_valid && out_stall)) begin
								if (out_valid) out_valid <= 1'b0;
								final_result <= 1'b0;
								found_q <= 1'b0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
